// File: rtl/rvp_pkg.sv
package rvp_pkg;

  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

  localparam logic [1:0] CfgMaxPkt   = 2'd0;
  localparam logic [1:0] CfgPayType  = 2'd1;
  localparam logic [1:0] CfgStartSeq = 2'd2;
  localparam logic [1:0] CfgSsrc     = 2'd3;

  localparam logic [15:0] ResetMaxPkt  = 16'd1400;
  localparam logic [6:0]  ResetPayType = 7'd96;

  // fixed header plus descriptor
  localparam logic [15:0] OverheadBytes = 16'd13;

  localparam logic [7:0] HdrByte0   = 8'h80;
  localparam logic [7:0] DescFirst  = 8'h10;
  localparam logic [7:0] DescLater  = 8'h00;

  // byte positions within an opening burst
  localparam logic [3:0] IdxVer    = 4'd0;
  localparam logic [3:0] IdxPt     = 4'd1;
  localparam logic [3:0] IdxSeqHi  = 4'd2;
  localparam logic [3:0] IdxSeqLo  = 4'd3;
  localparam logic [3:0] IdxTs3    = 4'd4;
  localparam logic [3:0] IdxTs2    = 4'd5;
  localparam logic [3:0] IdxTs1    = 4'd6;
  localparam logic [3:0] IdxTs0    = 4'd7;
  localparam logic [3:0] IdxSsrc3  = 4'd8;
  localparam logic [3:0] IdxSsrc2  = 4'd9;
  localparam logic [3:0] IdxSsrc1  = 4'd10;
  localparam logic [3:0] IdxSsrc0  = 4'd11;
  localparam logic [3:0] IdxDesc   = 4'd12;
  localparam logic [3:0] IdxData   = 4'd13;

  typedef struct packed {
    logic [7:0]  data;
    logic        open;
    logic        marker;
    logic        first;
    logic        eop;
    logic [15:0] seq;
    logic [31:0] ts;
  } rvp_entry_t;

endpackage

// File: rtl/rtp_vp8_packetizer.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------------------
// input    | in_valid_i / in_ready_o    | op_i, frame_length_i, frame_timestamp_i, data_byte_i
// output   | out_valid_o / out_ready_i  | out_byte_o, packet_start_o, end_of_packet_o, last_of_run_o
// config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// The front takes one item per cycle while the queue has room; a start item or a
// dropped byte makes no output.
// The back sends one byte per cycle from its output register while out_ready_i allows;
// a byte that opens a packet follows 13 header and descriptor bytes, others go alone.
// Within a packet payload flows at one byte per cycle; each packet's header holds it back.
// Output stalls fill the queue (QueueDepth entries), then drop in_ready_o.
// Reset loads the register defaults and leaves no frame open.
module rtp_vp8_packetizer
  import rvp_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [23:0] frame_length_i,
  input  logic [31:0] frame_timestamp_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_start_o,
  output logic        end_of_packet_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [15:0] max_pkt_q;
  logic [6:0]  pay_type_q;
  logic [31:0] ssrc_q;

  logic        accept;
  logic        push;
  logic        pop;
  logic        full;
  logic        head_valid;
  rvp_entry_t  push_entry;
  rvp_entry_t  head_entry;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q  <= ResetMaxPkt;
      pay_type_q <= ResetPayType;
      ssrc_q     <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxPkt:  max_pkt_q  <= cfg_data_i[15:0];
        CfgPayType: pay_type_q <= cfg_data_i[6:0];
        CfgSsrc:    ssrc_q     <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  rvp_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i          (accept),
    .op_i,
    .frame_length_i,
    .frame_timestamp_i,
    .data_byte_i,
    .max_pkt_i         (max_pkt_q),
    .seq_load_i        (cfg_we_i && (cfg_idx_i == CfgStartSeq)),
    .seq_load_val_i    (cfg_data_i[15:0]),
    .push_o            (push),
    .entry_o           (push_entry)
  );

  rvp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .full_o      (full),
    .valid_o     (head_valid),
    .head_o      (head_entry)
  );

  rvp_back u_back (
    .clk_i,
    .rst_ni,
    .entry_valid_i   (head_valid),
    .entry_i         (head_entry),
    .pop_o           (pop),
    .pay_type_i      (pay_type_q),
    .ssrc_i          (ssrc_q),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .packet_start_o,
    .end_of_packet_o,
    .last_of_run_o
  );

  a_start_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_start_o |-> (out_byte_o == HdrByte0) && !last_of_run_o)
    else $error("packet start not on a version byte");

  a_eop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_packet_o |-> last_of_run_o)
    else $error("end of packet before end of run");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !accept)
    else $error("item accepted with queue full");

  a_pop_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// File: rtl/rvp_front.sv
module rvp_front
  import rvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        op_i,
  input  logic [23:0] frame_length_i,
  input  logic [31:0] frame_timestamp_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] max_pkt_i,
  input  logic        seq_load_i,
  input  logic [15:0] seq_load_val_i,
  output logic        push_o,
  output rvp_entry_t  entry_o
);

  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic [23:0] rem_q, rem_d;
  logic [15:0] fill_q, fill_d;
  logic        first_q, first_d;

  logic [15:0] cap;
  logic [15:0] fill_inc;
  logic [23:0] rem_dec;
  logic        open;
  logic        eop;
  logic        take_data;

  assign cap       = (max_pkt_i <= OverheadBytes) ? 16'd1 : max_pkt_i - OverheadBytes;
  assign fill_inc  = fill_q + 16'd1;
  assign rem_dec   = rem_q - 24'd1;
  assign open      = (fill_q == 16'd0);
  assign eop       = (rem_dec == 24'd0) || (fill_inc >= cap);
  assign take_data = accept_i && (op_i == OpData) && (rem_q != 24'd0);

  assign push_o         = take_data;
  assign entry_o.data   = data_byte_i;
  assign entry_o.open   = open;
  assign entry_o.marker = (rem_q <= {8'd0, cap});
  assign entry_o.first  = first_q;
  assign entry_o.eop    = eop;
  assign entry_o.seq    = seq_q;
  assign entry_o.ts     = ts_q;

  always_comb begin
    seq_d   = seq_q;
    ts_d    = ts_q;
    rem_d   = rem_q;
    fill_d  = fill_q;
    first_d = first_q;
    if (accept_i && (op_i == OpStart)) begin
      // abandon any open packet and frame
      rem_d   = frame_length_i;
      ts_d    = frame_timestamp_i;
      fill_d  = 16'd0;
      first_d = 1'b1;
    end else if (take_data) begin
      rem_d  = rem_dec;
      fill_d = eop ? 16'd0 : fill_inc;
      if (open) begin
        first_d = 1'b0;
        seq_d   = seq_q + 16'd1;
      end
    end
    if (seq_load_i) begin
      seq_d = seq_load_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= 16'd0;
      ts_q    <= 32'd0;
      rem_q   <= 24'd0;
      fill_q  <= 16'd0;
      first_q <= 1'b1;
    end else begin
      seq_q   <= seq_d;
      ts_q    <= ts_d;
      rem_q   <= rem_d;
      fill_q  <= fill_d;
      first_q <= first_d;
    end
  end

endmodule

// File: rtl/rvp_fifo.sv
module rvp_fifo
  import rvp_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rvp_entry_t push_data_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output rvp_entry_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rvp_entry_t mem [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/rvp_back.sv
module rvp_back
  import rvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        entry_valid_i,
  input  rvp_entry_t  entry_i,
  output logic        pop_o,
  input  logic [6:0]  pay_type_i,
  input  logic [31:0] ssrc_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_start_o,
  output logic        end_of_packet_o,
  output logic        last_of_run_o
);

  logic [3:0] idx_q, idx_d;
  logic [3:0] cur_idx;
  logic       load;
  logic       last;
  logic [7:0] byte_sel;

  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       ps_q, eop_q, last_q;

  assign cur_idx = entry_i.open ? idx_q : IdxData;
  assign last    = (cur_idx == IdxData);
  assign load    = entry_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = load && last;

  always_comb begin
    case (cur_idx)
      IdxVer:   byte_sel = HdrByte0;
      IdxPt:    byte_sel = {entry_i.marker, pay_type_i};
      IdxSeqHi: byte_sel = entry_i.seq[15:8];
      IdxSeqLo: byte_sel = entry_i.seq[7:0];
      IdxTs3:   byte_sel = entry_i.ts[31:24];
      IdxTs2:   byte_sel = entry_i.ts[23:16];
      IdxTs1:   byte_sel = entry_i.ts[15:8];
      IdxTs0:   byte_sel = entry_i.ts[7:0];
      IdxSsrc3: byte_sel = ssrc_i[31:24];
      IdxSsrc2: byte_sel = ssrc_i[23:16];
      IdxSsrc1: byte_sel = ssrc_i[15:8];
      IdxSsrc0: byte_sel = ssrc_i[7:0];
      IdxDesc:  byte_sel = entry_i.first ? DescFirst : DescLater;
      default:  byte_sel = entry_i.data;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? IdxVer : idx_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IdxVer;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold payload until the transfer completes
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_sel;
      ps_q   <= (cur_idx == IdxVer);
      eop_q  <= last && entry_i.eop;
      last_q <= last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign packet_start_o  = ps_q;
  assign end_of_packet_o = eop_q;
  assign last_of_run_o   = last_q;

endmodule
